// ----- rtl/bounded_int_set_table_macros.svh -----
`ifndef BOUNDED_INT_SET_TABLE_MACROS_SVH
`define BOUNDED_INT_SET_TABLE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BIST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BIST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bist_pkg.sv -----
package bist_pkg;

  localparam int SlotsDefault = 8;
  localparam int ValueWidth   = 32;
  localparam int CountWidth   = 4;
  localparam int IndexWidth   = 3;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  localparam logic [1:0] REG_SLOTS_IN_USE = 2'd0;
  localparam logic [1:0] REG_RANGE_START  = 2'd1;
  localparam logic [1:0] REG_RANGE_END    = 2'd2;

  typedef struct packed {
    logic start;
    logic issue;
    logic eval;
    logic wb;
  } ctl_t;

  function automatic logic in_range(
    input logic signed [ValueWidth-1:0] v,
    input logic signed [ValueWidth-1:0] lo,
    input logic signed [ValueWidth-1:0] hi
  );
    return (v > lo) && (v < hi);
  endfunction

endpackage

// ----- rtl/bist_ram.sv -----
module bist_ram #(
  parameter int Width = 32,
  parameter int Depth = 8,
  localparam int AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AddrWidth-1:0] waddr,
  input  logic [Width-1:0]     wdata,
  input  logic                 re,
  input  logic [AddrWidth-1:0] raddr,
  output logic [Width-1:0]     rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/bist_seq.sv -----
module bist_seq import bist_pkg::*; #(
  parameter int Slots = SlotsDefault,
  localparam int AddrWidth = (Slots > 1) ? $clog2(Slots) : 1,
  localparam int CntWidth  = $clog2(Slots + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 out_free,
  input  logic [CntWidth-1:0]  used,
  output logic                 in_ready,
  output ctl_t                 ctl,
  output logic [AddrWidth-1:0] rd_addr,
  output logic [AddrWidth-1:0] ev_ptr
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_WB   = 2'd2;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [CntWidth-1:0] cnt;
  logic                p_vld;
  logic [AddrWidth-1:0] p_ptr;
  logic                issue;

  assign issue    = (state == S_SCAN) && (cnt < used);
  assign in_ready = (state == S_IDLE);
  assign rd_addr  = cnt[AddrWidth-1:0];
  assign ev_ptr   = p_ptr;

  always_comb begin
    ctl.start  = (state == S_IDLE) && in_valid;
    ctl.issue  = issue;
    ctl.eval   = (state == S_SCAN) && p_vld;
    ctl.wb     = (state == S_WB) && out_free;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!issue && !p_vld) begin
          state_next = S_WB;
        end
      end
      S_WB: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      p_vld <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.start) begin
        cnt   <= '0;
        p_vld <= 1'b0;
      end else if (state == S_SCAN) begin
        p_vld <= issue;
        if (issue) begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p_ptr <= cnt[AddrWidth-1:0];
    end
  end

endmodule

// ----- rtl/bounded_int_set_table.sv -----
// Fixed-capacity set of signed 32-bit values in SLOTS slots with valid bits.
// Input channel (in_valid/in_ready) takes one command per transaction: insert
// into the lowest free slot, remove the lowest matching slot, lookup, or read
// slot_index. Output channel (out_valid/out_ready) returns ok, read_value and
// the range flags, which describe the table after the command is applied.
// Config channel (cfg_valid/cfg_ready, always ready) writes slots_in_use,
// range_start or range_end by cfg_index; write it only while the block is idle.
// Each command scans the value RAM once over the n = min(slots_in_use, SLOTS)
// slots in use, one RAM read per cycle, then makes the last compare and writes
// back. A command is taken only while the sequencer is idle, so the next one
// is not accepted until the previous one has written back.
// The output register decouples the sides: a new command is accepted while an
// earlier result waits; the write-back stage holds while the receiver stalls.
// Reset clears all valid bits and the control state, sets slots_in_use to 8
// and the range to (0, 1); the value RAM is not cleared.
module bounded_int_set_table import bist_pkg::*; #(
  parameter int SLOTS = SlotsDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   command,
  input  logic signed [ValueWidth-1:0] item_value,
  input  logic [IndexWidth-1:0]        slot_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         ok,
  output logic signed [ValueWidth-1:0] read_value,
  output logic                         all_in_range,
  output logic                         any_in_range,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [ValueWidth-1:0]        cfg_data
);

  localparam int AddrWidth = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CntWidth  = $clog2(SLOTS + 1);

  logic [CountWidth-1:0]        slots_in_use;
  logic signed [ValueWidth-1:0] range_start;
  logic signed [ValueWidth-1:0] range_end;
  logic [CntWidth-1:0]          used;

  logic [1:0]                   cmd;
  logic signed [ValueWidth-1:0] val;
  logic [IndexWidth-1:0]        idx;

  logic [SLOTS-1:0]             slot_valid;
  ctl_t                         ctl;
  logic [AddrWidth-1:0]         rd_addr;
  logic [AddrWidth-1:0]         ev_ptr;
  logic signed [ValueWidth-1:0] rdata;

  logic                         found_m;
  logic                         found_f;
  logic [AddrWidth-1:0]         m_idx;
  logic [AddrWidth-1:0]         f_idx;
  logic                         rd_ok;
  logic signed [ValueWidth-1:0] rd_cap;
  logic                         acc_all;
  logic                         acc_any;

  logic ev_v;
  logic ev_match;
  logic ev_free;
  logic ev_keep;
  logic ev_in;
  logic ins_ok;
  logic rem_ok;
  logic val_in;
  logic fin_all;
  logic fin_any;
  logic fin_ok;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (32'(slots_in_use) > 32'(SLOTS)) begin
      used = CntWidth'(SLOTS);
    end else begin
      used = CntWidth'(slots_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= CountWidth'(8);
      range_start  <= '0;
      range_end    <= ValueWidth'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SLOTS_IN_USE: slots_in_use <= cfg_data[CountWidth-1:0];
        REG_RANGE_START:  range_start  <= cfg_data;
        REG_RANGE_END:    range_end    <= cfg_data;
        default: ;
      endcase
    end
  end

  bist_seq #(.Slots(SLOTS)) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (!out_valid || out_ready),
    .used     (used),
    .in_ready (in_ready),
    .ctl      (ctl),
    .rd_addr  (rd_addr),
    .ev_ptr   (ev_ptr)
  );

  bist_ram #(.Width(ValueWidth), .Depth(SLOTS)) u_ram (
    .clk   (clk),
    .we    (ctl.wb && ins_ok),
    .waddr (f_idx),
    .wdata (val),
    .re    (ctl.issue),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign ev_v     = slot_valid[ev_ptr];
  assign ev_match = ev_v && (rdata == val) && !found_m;
  assign ev_free  = !ev_v && !found_f;
  assign ev_keep  = ev_v && !((cmd == CMD_REMOVE) && ev_match);
  assign ev_in    = in_range(rdata, range_start, range_end);

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      cmd     <= command;
      val     <= item_value;
      idx     <= slot_index;
      found_m <= 1'b0;
      found_f <= 1'b0;
      rd_ok   <= 1'b0;
      acc_all <= 1'b1;
      acc_any <= 1'b0;
    end else if (ctl.eval) begin
      if (ev_match) begin
        found_m <= 1'b1;
        m_idx   <= ev_ptr;
      end
      if (ev_free) begin
        found_f <= 1'b1;
        f_idx   <= ev_ptr;
      end
      if (ev_v && (32'(ev_ptr) == 32'(idx))) begin
        rd_ok  <= 1'b1;
        rd_cap <= rdata;
      end
      if (ev_keep) begin
        if (ev_in) begin
          acc_any <= 1'b1;
        end else begin
          acc_all <= 1'b0;
        end
      end
    end
  end

  assign ins_ok = (cmd == CMD_INSERT) && found_f;
  assign rem_ok = (cmd == CMD_REMOVE) && found_m;
  assign val_in = in_range(val, range_start, range_end);

  always_comb begin
    fin_all = acc_all;
    fin_any = acc_any;
    if (ins_ok) begin
      fin_all = acc_all && val_in;
      fin_any = acc_any || val_in;
    end
    case (cmd)
      CMD_INSERT: fin_ok = found_f;
      CMD_REMOVE: fin_ok = found_m;
      CMD_LOOKUP: fin_ok = found_m;
      CMD_READ:   fin_ok = rd_ok;
      default:    fin_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (ctl.wb) begin
      if (ins_ok) begin
        slot_valid[f_idx] <= 1'b1;
      end else if (rem_ok) begin
        slot_valid[m_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.wb) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wb) begin
      ok           <= fin_ok;
      read_value   <= ((cmd == CMD_READ) && rd_ok) ? rd_cap : '0;
      all_in_range <= fin_all;
      any_in_range <= fin_any;
    end
  end

endmodule

// ----- rtl/bist_checker.sv -----
`include "bounded_int_set_table_macros.svh"

module bist_checker import bist_pkg::*; (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         ok,
  input logic signed [ValueWidth-1:0] read_value,
  input logic                         any_in_range,
  input logic                         all_in_range,
  input logic signed [ValueWidth-1:0] range_start,
  input logic signed [ValueWidth-1:0] range_end
);

  logic empty_range;

  assign empty_range = (range_start >= range_end);

  `BIST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `BIST_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(ok) && $stable(read_value) && $stable(all_in_range) && $stable(any_in_range), "result changed while stalled")
  `BIST_ASSERT_NOW(a_rd_zero, out_valid && !ok, read_value == '0, "read_value nonzero on failure")
  `BIST_ASSERT_NOW(a_empty_any, out_valid && empty_range, !any_in_range, "any flag set for empty range")
  `BIST_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "second command taken during scan")

endmodule

bind bounded_int_set_table bist_checker u_bist_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .ok           (ok),
  .read_value   (read_value),
  .any_in_range (any_in_range),
  .all_in_range (all_in_range),
  .range_start  (range_start),
  .range_end    (range_end)
);
